@@ hw/rtl/assert_macros.svh @@
// assertion helpers, sampled on the rising clock edge and ignored while reset is applied
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define TMC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define TMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/tmc_pkg.sv @@
`default_nettype none

package tmc_pkg;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LINE = 2'd1,
        PH_MARK = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        DEC_STRAIGHT      = 3'd0,
        DEC_MEAS_STRAIGHT = 3'd1,
        DEC_CURVE_RIGHT   = 3'd2,
        DEC_CURVE_LEFT    = 3'd3,
        DEC_END_MARK      = 3'd4
    } decision_t;

    localparam logic [7:0] LINE_ONLY_PATTERN = 8'h7e;
    localparam logic [7:0] ALL_ONES_PATTERN  = 8'hff;
    localparam logic [7:0] MARKER_MASK       = 8'h81;
    localparam logic [2:0] THRESHOLD_RESET   = 3'd4;

    typedef struct packed {
        phase_t    phase;
        logic [7:0] accumulated;
        logic      end_seen;
        decision_t decision;
    } state_t;

    typedef struct packed {
        decision_t  decision;
        logic       event_closed;
        logic [7:0] pattern;
    } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/track_marker_classifier_core.sv @@
// Track marker classifier: one 8-bit sensor sample per transaction (bits 1-6 line sensors,
// bit 0 right marker, bit 7 left marker) gives one result transaction carrying the current
// driving decision, a flag for a closed event and the ORed event pattern. A sample is taken
// every clock cycle while in_stall is low; its result is registered, the popcount and
// classification being one combinational pass ahead of the result register. A two-entry
// output buffer (result register plus skid register) keeps intake running while the result
// side stalls; in_stall rises only when both entries are full. line_threshold is written
// through the cfg port (always ready), resets to 4 and must only change while idle.

`default_nettype none

module track_marker_classifier_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output      logic       in_stall,
    input  wire logic [7:0] sensor_bits,
    output      logic       out_valid,
    input  wire logic       out_stall,
    output      logic [2:0] decision,
    output      logic       event_closed,
    output      logic [7:0] pattern,
    input  wire logic       cfg_valid,
    output      logic       cfg_ready,
    input  wire logic [2:0] cfg_data
);
    import tmc_pkg::*;

    `include "assert_macros.svh"

    logic [2:0] threshold_reg;
    state_t     state_reg;
    state_t     state_next;
    result_t    step_res;
    result_t    out_res_reg;
    result_t    out_res_next;
    result_t    skid_res_reg;
    result_t    skid_res_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       skid_valid_reg;
    logic       skid_valid_next;
    logic       in_accept;
    logic       out_take;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    tmc_step u_step (
        .sensor_bits    (sensor_bits),
        .line_threshold (threshold_reg),
        .state_cur      (state_reg),
        .state_new      (state_next),
        .result         (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            threshold_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase       <= PH_IDLE;
            state_reg.accumulated <= 8'h00;
            state_reg.end_seen    <= 1'b0;
            state_reg.decision    <= DEC_STRAIGHT;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    // two-entry output buffer, skid entry drains first to keep order
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_res_next    = out_res_reg;
        skid_valid_next = skid_valid_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_accept;
                out_res_next   = step_res;
            end
        end
        else if (in_accept)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = step_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign out_valid    = out_valid_reg;
    assign decision     = 3'(out_res_reg.decision);
    assign event_closed = out_res_reg.event_closed;
    assign pattern      = out_res_reg.pattern;

    `TMC_ASSERT(a_skid_needs_out, !skid_valid_reg || out_valid_reg,
        "skid entry holds data while result register is empty")
    `TMC_ASSERT_NEXT(a_stalled_accept_to_skid, in_accept && out_valid_reg && out_stall,
        skid_valid_reg, "accepted sample lost while result side stalled")
    `TMC_ASSERT_NEXT(a_end_seen_sticky, state_reg.end_seen, state_reg.end_seen,
        "end line flag cleared after being set")
    `TMC_ASSERT(a_decision_range, !out_valid_reg || (decision <= 3'(DEC_END_MARK)),
        "decision code out of range")

endmodule

`default_nettype wire

@@ hw/rtl/tmc_step.sv @@
`default_nettype none

module tmc_step (
    input  wire logic [7:0]     sensor_bits,
    input  wire logic [2:0]     line_threshold,
    input  tmc_pkg::state_t     state_cur,
    output tmc_pkg::state_t     state_new,
    output tmc_pkg::result_t    result
);
    import tmc_pkg::*;

    logic [2:0] line_cnt;
    logic       line_hit;
    logic       mark_hit;
    logic       do_close;
    logic       do_classify;
    logic [7:0] cls_pat;
    logic       cls_end_seen;
    decision_t  cls_dec;
    phase_t     open_phase;
    logic [7:0] open_acc;

    always_comb
    begin
        line_cnt = 3'd0;
        for (int b = 1; b <= 6; b++)
        begin
            line_cnt = line_cnt + {2'd0, sensor_bits[b]};
        end
    end

    assign line_hit = (line_cnt >= line_threshold);
    assign mark_hit = |(sensor_bits & MARKER_MASK);

    // what the sample would start if looked at from idle
    always_comb
    begin
        priority if (line_hit)
        begin
            open_phase = PH_LINE;
            open_acc   = sensor_bits;
        end
        else if (mark_hit)
        begin
            open_phase = PH_MARK;
            open_acc   = sensor_bits;
        end
        else
        begin
            open_phase = PH_IDLE;
            open_acc   = 8'h00;
        end
    end

    always_comb
    begin
        unique case (state_cur.phase)
            PH_LINE:
            begin
                do_close    = !line_hit;
                do_classify = !line_hit && (state_cur.accumulated != LINE_ONLY_PATTERN);
            end
            PH_MARK:
            begin
                do_close    = !mark_hit;
                do_classify = !mark_hit;
            end
            default:
            begin
                do_close    = 1'b0;
                do_classify = 1'b0;
            end
        endcase
    end

    // classification of the closed pattern
    always_comb
    begin
        cls_pat      = state_cur.accumulated;
        cls_end_seen = state_cur.end_seen;
        cls_dec      = state_cur.decision;
        if (do_classify)
        begin
            priority if (cls_pat == ALL_ONES_PATTERN)
            begin
                cls_dec = DEC_MEAS_STRAIGHT;
            end
            else if (cls_pat[0] && cls_pat[7])
            begin
                if (state_cur.end_seen)
                    cls_dec = DEC_END_MARK;
                else
                    cls_end_seen = 1'b1;
            end
            else if (cls_pat[0])
            begin
                cls_dec = (state_cur.decision == DEC_CURVE_RIGHT) ?
                          DEC_MEAS_STRAIGHT : DEC_CURVE_RIGHT;
            end
            else if (cls_pat[7])
            begin
                cls_dec = (state_cur.decision == DEC_CURVE_LEFT) ?
                          DEC_MEAS_STRAIGHT : DEC_CURVE_LEFT;
            end
            else
            begin
                // no marker in the pattern keeps the decision
                cls_dec = state_cur.decision;
            end
        end
    end

    always_comb
    begin
        state_new.end_seen = cls_end_seen;
        state_new.decision = cls_dec;
        unique case (state_cur.phase)
            PH_LINE, PH_MARK:
            begin
                if (do_close)
                begin
                    state_new.phase       = open_phase;
                    state_new.accumulated = open_acc;
                end
                else
                begin
                    state_new.phase       = state_cur.phase;
                    state_new.accumulated = state_cur.accumulated | sensor_bits;
                end
            end
            default:
            begin
                state_new.phase       = open_phase;
                state_new.accumulated = open_acc;
            end
        endcase
    end

    always_comb
    begin
        result.decision     = state_new.decision;
        result.event_closed = do_close;
        result.pattern      = do_close ? state_cur.accumulated : state_new.accumulated;
    end

endmodule

`default_nettype wire
